FILE: rtl/bounded_byte_fifo_macros.svh
// Assertion macros used by the checker of this block.
`ifndef BOUNDED_BYTE_FIFO_MACROS_SVH
`define BOUNDED_BYTE_FIFO_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/bbf_pkg.sv
`default_nettype none
package bbf_pkg;

   // Storage depth must be a power of two so that pointers wrap by truncation.
   localparam int DEPTH      = 1024;
   localparam int MAX_RUN    = 64;
   localparam int PTR_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CAP_W      = 11;
   localparam int CMD_W      = 3;
   localparam int BYTE_W     = 8;
   localparam int CNT_IN_W   = 7;
   localparam int RUN_W      = $clog2(MAX_RUN + 1);
   localparam int OCC_W      = 11;
   localparam int TOT_W      = 48;
   localparam int SEL_W      = (CNT_W > CNT_IN_W) ? CNT_W : CNT_IN_W;
   localparam int JOBQ_DEPTH = 2;
   localparam int OQ_DEPTH   = 2;
   localparam int PEND_W     = $clog2(MAX_RUN * (JOBQ_DEPTH + 1) + 1);

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 3'd0,
      CMD_READ  = 3'd1,
      CMD_PEEK  = 3'd2,
      CMD_POP   = 3'd3,
      CMD_END   = 3'd4
   } cmd_type;

   typedef struct packed {
      logic             accepted;
      logic [OCC_W-1:0] occupancy;
      logic [OCC_W-1:0] room_left;
      logic [TOT_W-1:0] total_in;
      logic [TOT_W-1:0] total_out;
      logic             ended;
      logic             at_eof;
   } status_type;

   typedef struct packed {
      status_type       status;
      logic [PTR_W-1:0] start_ptr;
      logic [RUN_W-1:0] nbytes;
   } job_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic              last;
      status_type        status;
   } result_type;

   function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
                                                input logic [CNT_IN_W-1:0] b);
      logic [TOT_W:0] sum;
      sum = {1'b0, a} + (TOT_W + 1)'(b);
      return sum[TOT_W] ? '1 : sum[TOT_W-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/bbf_ram.sv
`default_nettype none
module bbf_ram #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: rtl/bbf_front.sv
`default_nettype none
module bbf_front import bbf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [CAP_W-1:0]    csr_wr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic [CNT_IN_W-1:0] req_count,
   output logic                job_valid,
   input  logic                job_ready,
   output job_type             job,
   input  logic                drain_beat,
   output logic                mem_wr_en,
   output logic [PTR_W-1:0]    mem_wr_addr,
   output logic [BYTE_W-1:0]   mem_wr_data
);

   logic [CAP_W-1:0]    capacity_ff;
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    held_ff, held_in;
   logic [TOT_W-1:0]    total_in_ff, total_in_in;
   logic [TOT_W-1:0]    total_out_ff, total_out_in;
   logic                ended_ff, ended_in;
   logic [PEND_W-1:0]   pending_ff, pending_in;

   logic [CNT_W-1:0]    eff_cap;
   logic [SEL_W-1:0]    take;
   logic [RUN_W-1:0]    run_n;
   logic [CNT_IN_W-1:0] drop_n;
   logic [RUN_W-1:0]    nbytes;
   logic                acc;
   logic                write_ok;
   logic                write_block;
   logic                accept;

   always_comb begin
      if (32'(capacity_ff) > 32'(DEPTH)) begin
         eff_cap = CNT_W'(DEPTH);
      end else begin
         eff_cap = CNT_W'(capacity_ff);
      end
      take  = (SEL_W'(req_count) < SEL_W'(held_ff)) ? SEL_W'(req_count) : SEL_W'(held_ff);
      run_n = (take > SEL_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : RUN_W'(take);
   end

   assign write_ok = held_ff < eff_cap;

   // A write must not land on a slot that a queued read or peek has yet to fetch.
   // Peeked bytes that a later pop frees are covered by counting every queued byte.
   assign write_block = (req_cmd == CMD_WRITE) &&
                        ((32'(held_ff) + 32'(pending_ff)) >= 32'(DEPTH));
   assign req_ready   = job_ready && !write_block;
   assign accept      = req_valid && req_ready;

   always_comb begin
      acc       = 1'b0;
      drop_n    = '0;
      nbytes    = '0;
      ended_in  = ended_ff;
      mem_wr_en = 1'b0;
      if (accept) begin
         case (req_cmd)
            CMD_WRITE: begin
               acc       = write_ok;
               mem_wr_en = write_ok;
            end
            CMD_READ: begin
               drop_n = CNT_IN_W'(run_n);
               nbytes = run_n;
            end
            CMD_PEEK: begin
               nbytes = run_n;
            end
            CMD_POP: begin
               drop_n = CNT_IN_W'(take);
            end
            CMD_END: begin
               ended_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
      head_in      = head_ff + PTR_W'(drop_n);
      held_in      = held_ff + CNT_W'(acc) - CNT_W'(drop_n);
      total_in_in  = sat_add(total_in_ff, CNT_IN_W'(acc));
      total_out_in = sat_add(total_out_ff, drop_n);
      pending_in   = pending_ff + PEND_W'(nbytes) - PEND_W'(drain_beat);
   end

   assign mem_wr_addr = head_ff + PTR_W'(held_ff);
   assign mem_wr_data = req_data_byte;

   always_comb begin
      job_valid               = accept;
      job.start_ptr           = head_ff;
      job.nbytes              = nbytes;
      job.status.accepted     = acc;
      job.status.occupancy    = OCC_W'(held_in);
      job.status.room_left    = (eff_cap > held_in) ? OCC_W'(eff_cap - held_in) : '0;
      job.status.total_in     = total_in_in;
      job.status.total_out    = total_out_in;
      job.status.ended        = ended_in;
      job.status.at_eof       = ended_in && (held_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         head_ff      <= '0;
         held_ff      <= '0;
         total_in_ff  <= '0;
         total_out_ff <= '0;
         ended_ff     <= 1'b0;
         pending_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         head_ff      <= head_in;
         held_ff      <= held_in;
         total_in_ff  <= total_in_in;
         total_out_ff <= total_out_in;
         ended_ff     <= ended_in;
         pending_ff   <= pending_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/bbf_job_queue.sv
`default_nettype none
module bbf_job_queue import bbf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_job
);

   localparam int QP_W = $clog2(JOBQ_DEPTH);
   localparam int QC_W = $clog2(JOBQ_DEPTH + 1);

   job_type          entry_ff [JOBQ_DEPTH];
   logic [QP_W-1:0]  wr_ff, wr_in;
   logic [QP_W-1:0]  rd_ff, rd_in;
   logic [QC_W-1:0]  cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready  = cnt_ff != QC_W'(JOBQ_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_job   = entry_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? wr_ff + QP_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + QP_W'(1) : rd_ff;
      cnt_in = cnt_ff + QC_W'(push) - QC_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= in_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/bbf_back.sv
`default_nettype none
module bbf_back import bbf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  job_type           job,
   output logic              mem_rd_en,
   output logic [PTR_W-1:0]  mem_rd_addr,
   input  logic [BYTE_W-1:0] mem_rd_data,
   output logic              drain_beat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output result_type        rsp_beat
);

   localparam int OP_W = $clog2(OQ_DEPTH);
   localparam int OC_W = $clog2(OQ_DEPTH + 1);

   logic [RUN_W-1:0] idx_ff, idx_in;
   logic             s1_valid_ff;
   logic             s1_bv_ff;
   logic             s1_last_ff;
   status_type       s1_status_ff;

   result_type       oq_ff [OQ_DEPTH];
   logic [OP_W-1:0]  oq_wr_ff, oq_rd_ff;
   logic [OC_W-1:0]  oq_cnt_ff;

   logic             pop;
   logic             room;
   logic             issue;
   logic             status_only;
   logic             last_beat;
   result_type       push_beat;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = oq_cnt_ff != '0;
   assign rsp_beat  = oq_ff[oq_rd_ff];

   // A beat is issued only if the output queue will have a slot for it when the
   // RAM data returns, counting the beat already in flight.
   assign room = (32'(oq_cnt_ff) + 32'(s1_valid_ff) - 32'(pop)) < 32'(OQ_DEPTH);

   assign issue       = job_valid && room;
   assign status_only = job.nbytes == '0;
   assign last_beat   = status_only || ((idx_ff + RUN_W'(1)) == job.nbytes);
   assign job_ready   = issue && last_beat;

   assign mem_rd_en   = issue && !status_only;
   assign mem_rd_addr = job.start_ptr + PTR_W'(idx_ff);
   assign drain_beat  = mem_rd_en;

   always_comb begin
      if (issue) begin
         idx_in = last_beat ? '0 : idx_ff + RUN_W'(1);
      end else begin
         idx_in = idx_ff;
      end
      push_beat.out_byte   = s1_bv_ff ? mem_rd_data : '0;
      push_beat.byte_valid = s1_bv_ff;
      push_beat.last       = s1_last_ff;
      push_beat.status     = s1_status_ff;
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_bv_ff     <= !status_only;
         s1_last_ff   <= last_beat;
         s1_status_ff <= job.status;
      end
      if (s1_valid_ff) begin
         oq_ff[oq_wr_ff] <= push_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         s1_valid_ff <= 1'b0;
         oq_wr_ff    <= '0;
         oq_rd_ff    <= '0;
         oq_cnt_ff   <= '0;
      end else begin
         idx_ff      <= idx_in;
         s1_valid_ff <= issue;
         if (s1_valid_ff) begin
            oq_wr_ff <= oq_wr_ff + OP_W'(1);
         end
         if (pop) begin
            oq_rd_ff <= oq_rd_ff + OP_W'(1);
         end
         oq_cnt_ff <= oq_cnt_ff + OC_W'(s1_valid_ff) - OC_W'(pop);
      end
   end

endmodule
`default_nettype wire

FILE: rtl/bounded_byte_fifo.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  cmd, data_byte, count
// rsp       out        rsp_valid/rsp_ready  byte, flags, occupancy, room, totals, eof
// csr       in         csr_wr_en            capacity
//
// Write, pop, end-input and unknown commands can be accepted every cycle while req_ready
// is high; a read or peek of n bytes yields n beats, one byte per cycle from the single RAM
// read port while the output queue has room, after passing the job queue and read stage.
// Reset is synchronous, clears all control state and sets the capacity to 1024; the byte store is not cleared.
// A write stalls while held bytes plus bytes still queued for fetch fill the store,
// and any beat stalls while the job queue is full.
`default_nettype none
module bounded_byte_fifo import bbf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [CAP_W-1:0]    csr_wr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic [CNT_IN_W-1:0] req_count,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BYTE_W-1:0]   rsp_out_byte,
   output logic                rsp_byte_valid,
   output logic                rsp_last,
   output logic                rsp_accepted,
   output logic [OCC_W-1:0]    rsp_occupancy,
   output logic [OCC_W-1:0]    rsp_room_left,
   output logic [TOT_W-1:0]    rsp_total_in,
   output logic [TOT_W-1:0]    rsp_total_out,
   output logic                rsp_ended,
   output logic                rsp_at_eof
);

   logic              fq_valid, fq_ready;
   job_type           fq_job;
   logic              qb_valid, qb_ready;
   job_type           qb_job;
   logic              drain_beat;
   logic              mem_wr_en;
   logic [PTR_W-1:0]  mem_wr_addr;
   logic [BYTE_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [PTR_W-1:0]  mem_rd_addr;
   logic [BYTE_W-1:0] mem_rd_data;
   result_type        rsp_beat;

   bbf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .req_count     (req_count),
      .job_valid     (fq_valid),
      .job_ready     (fq_ready),
      .job           (fq_job),
      .drain_beat    (drain_beat),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data)
   );

   bbf_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_job    (fq_job),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_job   (qb_job)
   );

   bbf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (qb_valid),
      .job_ready   (qb_ready),
      .job         (qb_job),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .drain_beat  (drain_beat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_beat    (rsp_beat)
   );

   bbf_ram #(
      .ADDR_W (PTR_W),
      .DATA_W (BYTE_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_out_byte   = rsp_beat.out_byte;
   assign rsp_byte_valid = rsp_beat.byte_valid;
   assign rsp_last       = rsp_beat.last;
   assign rsp_accepted   = rsp_beat.status.accepted;
   assign rsp_occupancy  = rsp_beat.status.occupancy;
   assign rsp_room_left  = rsp_beat.status.room_left;
   assign rsp_total_in   = rsp_beat.status.total_in;
   assign rsp_total_out  = rsp_beat.status.total_out;
   assign rsp_ended      = rsp_beat.status.ended;
   assign rsp_at_eof     = rsp_beat.status.at_eof;

endmodule
`default_nettype wire

FILE: rtl/bbf_checker.sv
`default_nettype none
`include "bounded_byte_fifo_macros.svh"
module bbf_checker import bbf_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [CMD_W-1:0]    req_cmd,
   input logic [BYTE_W-1:0]   req_data_byte,
   input logic [CNT_IN_W-1:0] req_count,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [BYTE_W-1:0]   rsp_out_byte,
   input logic                rsp_byte_valid,
   input logic                rsp_last,
   input logic                rsp_accepted,
   input logic [OCC_W-1:0]    rsp_occupancy,
   input logic [OCC_W-1:0]    rsp_room_left,
   input logic [TOT_W-1:0]    rsp_total_in,
   input logic [TOT_W-1:0]    rsp_total_out,
   input logic                rsp_ended,
   input logic                rsp_at_eof
);

   result_type                       rsp_word;
   logic [CMD_W+BYTE_W+CNT_IN_W-1:0] req_word;

   assign rsp_word = {rsp_out_byte, rsp_byte_valid, rsp_last, rsp_accepted, rsp_occupancy,
                      rsp_room_left, rsp_total_in, rsp_total_out, rsp_ended, rsp_at_eof};
   assign req_word = {req_cmd, req_data_byte, req_count};

   // A stalled result beat must hold every field.
   `BBF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "stalled result beat changed")

   // A stalled request beat keeps its valid and payload.
   `BBF_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid && $stable(req_word), "stalled request beat changed")

   // A beat without a byte is a lone status beat and closes its run.
   `BBF_ASSERT_NOW(a_status_last, clock, reset, rsp_valid && !rsp_byte_valid, rsp_last && (rsp_out_byte == '0), "status beat not last or carries a byte")

   // End of stream means input ended and nothing is held.
   `BBF_ASSERT_NOW(a_eof_flag, clock, reset, rsp_valid, rsp_at_eof == (rsp_ended && (rsp_occupancy == '0)), "end-of-stream flag inconsistent")

   // Held bytes plus room never exceed the store.
   `BBF_ASSERT_NOW(a_occ_bound, clock, reset, rsp_valid, (32'(rsp_occupancy) + 32'(rsp_room_left)) <= 32'(DEPTH), "occupancy plus room exceeds depth")

endmodule

bind bounded_byte_fifo bbf_checker u_bbf_checker (.*);
`default_nettype wire

FILE: verif/bounded_byte_fifo_tb.sv
`timescale 1ns / 1ps

module bounded_byte_fifo_tb;
   import bbf_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 8;

   // Command codes that the block must ignore apart from a status beat.
   localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

   localparam logic [TOT_W-1:0] TOTAL_CEIL = '1;

   typedef struct {
      logic [CMD_W-1:0]    cmd;
      logic [BYTE_W-1:0]   data;
      logic [CNT_IN_W-1:0] count;
      bit                  pinned;
      bit                  pin_acc;
      logic [OCC_W-1:0]    pin_occ;
   } cmd_beat_type;

   logic                clock;
   logic                reset          = 1'b1;
   logic                csr_wr_en      = 1'b0;
   logic [CAP_W-1:0]    csr_wr_data    = '0;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd        = '0;
   logic [BYTE_W-1:0]   req_data_byte  = '0;
   logic [CNT_IN_W-1:0] req_count      = '0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_byte_valid;
   logic                rsp_last;
   logic                rsp_accepted;
   logic [OCC_W-1:0]    rsp_occupancy;
   logic [OCC_W-1:0]    rsp_room_left;
   logic [TOT_W-1:0]    rsp_total_in;
   logic [TOT_W-1:0]    rsp_total_out;
   logic                rsp_ended;
   logic                rsp_at_eof;

   bounded_byte_fifo DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_data_byte  (req_data_byte),
      .req_count      (req_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_last),
      .rsp_accepted   (rsp_accepted),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_room_left  (rsp_room_left),
      .rsp_total_in   (rsp_total_in),
      .rsp_total_out  (rsp_total_out),
      .rsp_ended      (rsp_ended),
      .rsp_at_eof     (rsp_at_eof)
   );

   // Shadow copy of the buffer state and the capacity register.
   logic [BYTE_W-1:0] shadow_store [DEPTH];
   logic [PTR_W-1:0]  shadow_head;
   logic [OCC_W-1:0]  shadow_held;
   logic [TOT_W-1:0]  shadow_in_total;
   logic [TOT_W-1:0]  shadow_out_total;
   bit                shadow_done;
   logic [CAP_W-1:0]  shadow_cap;

   result_type   due_results [$];
   cmd_beat_type directed [$];
   int           fault_count    = 0;
   int           result_count   = 0;
   int unsigned  cycle_count    = 0;
   int           send_idle_pct  = 0;
   int           recv_stall_pct = 0;
   logic         hold_request   = 1'b0;
   bit           hold_taken     = 1'b0;
   int           hold_left      = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [OCC_W-1:0] usable_capacity();
      return (shadow_cap > DEPTH) ? OCC_W'(DEPTH) : shadow_cap;
   endfunction

   function automatic logic [TOT_W-1:0] bump_total(logic [TOT_W-1:0] t, int n);
      logic [TOT_W:0] sum;
      sum = {1'b0, t} + (TOT_W + 1)'(n);
      return (sum > {1'b0, TOTAL_CEIL}) ? TOTAL_CEIL : sum[TOT_W-1:0];
   endfunction

   task automatic discard_bytes(int n);
      shadow_head      = PTR_W'(shadow_head + n);
      shadow_held      = shadow_held - OCC_W'(n);
      shadow_out_total = bump_total(shadow_out_total, n);
   endtask

   // Applies one accepted command to the shadow state and queues the beats it owes.
   task automatic replay_command(cmd_beat_type b);
      result_type        r;
      logic [BYTE_W-1:0] run_bytes [MAX_RUN];
      int                n;
      int                i;
      r = '0;
      n = 0;
      case (b.cmd)
         CMD_WRITE: begin
            if (shadow_held < usable_capacity()) begin
               shadow_store[PTR_W'(shadow_head + shadow_held)] = b.data;
               shadow_held        = shadow_held + 1'b1;
               shadow_in_total    = bump_total(shadow_in_total, 1);
               r.status.accepted  = 1'b1;
            end
         end
         CMD_READ, CMD_PEEK: begin
            n = (b.count < shadow_held) ? b.count : shadow_held;
            if (n > MAX_RUN) n = MAX_RUN;
            for (i = 0; i < n; i++) run_bytes[i] = shadow_store[PTR_W'(shadow_head + i)];
            if (b.cmd == CMD_READ) discard_bytes(n);
         end
         CMD_POP: begin
            discard_bytes((b.count < shadow_held) ? b.count : shadow_held);
         end
         CMD_END: begin
            shadow_done = 1'b1;
         end
         default: ;
      endcase
      r.status.occupancy = shadow_held;
      r.status.room_left = (usable_capacity() > shadow_held) ?
                           usable_capacity() - shadow_held : '0;
      r.status.total_in  = shadow_in_total;
      r.status.total_out = shadow_out_total;
      r.status.ended     = shadow_done;
      r.status.at_eof    = shadow_done && (shadow_held == 0);
      if (n == 0) begin
         r.last = 1'b1;
         if (b.pinned) begin
            r.status.accepted  = b.pin_acc;
            r.status.occupancy = b.pin_occ;
         end
         due_results = {due_results, r};
      end else begin
         for (i = 0; i < n; i++) begin
            r.out_byte   = run_bytes[i];
            r.byte_valid = 1'b1;
            r.last       = (i == n - 1);
            due_results = {due_results, r};
         end
      end
   endtask

   function automatic cmd_beat_type row(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                                        logic [CNT_IN_W-1:0] count, bit pinned = 1'b0,
                                        bit acc = 1'b0, logic [OCC_W-1:0] occ = '0);
      cmd_beat_type b;
      b.cmd     = cmd;
      b.data    = data;
      b.count   = count;
      b.pinned  = pinned;
      b.pin_acc = acc;
      b.pin_occ = occ;
      return b;
   endfunction

   // Mostly writes and short reads, with the odd long request, end marker and junk code.
   function automatic cmd_beat_type random_beat(int write_pct);
      cmd_beat_type b;
      int           pick;
      b = row(CMD_WRITE, 8'($urandom), '0);
      pick = $urandom_range(99);
      if (pick >= write_pct) begin
         pick = $urandom_range(99);
         if (pick < 40) b.cmd = CMD_READ;
         else if (pick < 65) b.cmd = CMD_PEEK;
         else if (pick < 85) b.cmd = CMD_POP;
         else if (pick < 93) b.cmd = CMD_END;
         else begin
            case ($urandom_range(2))
               0: b.cmd = CMD_RSVD5;
               1: b.cmd = CMD_RSVD6;
               default: b.cmd = CMD_RSVD7;
            endcase
         end
      end
      pick = $urandom_range(99);
      if (pick < 70) b.count = 7'($urandom_range(8));
      else if (pick < 90) b.count = 7'($urandom_range(64));
      else b.count = 7'($urandom_range(127, 65));
      return b;
   endfunction

   task automatic send_beat(cmd_beat_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= b.cmd;
      req_data_byte <= b.data;
      req_count     <= b.count;
      do @(posedge clock); while (!req_ready);
      replay_command(b);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_capacity(logic [CAP_W-1:0] value);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shadow_cap   = value;
   endtask

   task automatic run_phase(logic [CAP_W-1:0] cap, int send_pct, int recv_pct,
                            int write_pct, int beats);
      set_capacity(cap);
      send_idle_pct   = send_pct;
      recv_stall_pct <= recv_pct;
      repeat (beats) send_beat(random_beat(write_pct));
   endtask

   task automatic note_fault(string msg);
      fault_count++;
      if (fault_count <= 10) $display("%s", msg);
   endtask

   function automatic string show_result(result_type r);
      return $sformatf("byte=%02h v=%0b last=%0b acc=%0b occ=%0d room=%0d in=%0d out=%0d end=%0b eof=%0b",
                       r.out_byte, r.byte_valid, r.last, r.status.accepted,
                       r.status.occupancy, r.status.room_left, r.status.total_in,
                       r.status.total_out, r.status.ended, r.status.at_eof);
   endfunction

   // Receiver: random stalls, plus one long hold-off requested by the stimulus.
   always @(posedge clock) begin
      if (hold_request && !hold_taken) begin
         hold_left  = LONG_HOLD;
         hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      result_type seen;
      result_type want;
      string      bad;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.out_byte         = rsp_out_byte;
         seen.byte_valid       = rsp_byte_valid;
         seen.last             = rsp_last;
         seen.status.accepted  = rsp_accepted;
         seen.status.occupancy = rsp_occupancy;
         seen.status.room_left = rsp_room_left;
         seen.status.total_in  = rsp_total_in;
         seen.status.total_out = rsp_total_out;
         seen.status.ended     = rsp_ended;
         seen.status.at_eof    = rsp_at_eof;
         if (due_results.size() == 0) begin
            note_fault($sformatf("result %0d arrived with nothing expected: %s",
                                 result_count, show_result(seen)));
         end else begin
            want = due_results[0];
            due_results.delete(0);
            bad  = "";
            if (seen.out_byte !== want.out_byte) bad = {bad, " out_byte"};
            if (seen.byte_valid !== want.byte_valid) bad = {bad, " byte_valid"};
            if (seen.last !== want.last) bad = {bad, " last"};
            if (seen.status.accepted !== want.status.accepted) bad = {bad, " accepted"};
            if (seen.status.occupancy !== want.status.occupancy) bad = {bad, " occupancy"};
            if (seen.status.room_left !== want.status.room_left) bad = {bad, " room_left"};
            if (seen.status.total_in !== want.status.total_in) bad = {bad, " total_in"};
            if (seen.status.total_out !== want.status.total_out) bad = {bad, " total_out"};
            if (seen.status.ended !== want.status.ended) bad = {bad, " ended"};
            if (seen.status.at_eof !== want.status.at_eof) bad = {bad, " at_eof"};
            if (bad != "") begin
               note_fault($sformatf("result %0d mismatch in%s\n  expected %s\n  actual   %s",
                                    result_count, bad, show_result(want), show_result(seen)));
            end
         end
         result_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out with %0d results still expected", due_results.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      shadow_head      = '0;
      shadow_held      = '0;
      shadow_in_total  = '0;
      shadow_out_total = '0;
      shadow_done      = 1'b0;
      shadow_cap       = CAP_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty-buffer requests, junk codes, byte extremes, long runs,
      // end of input, a write after it, and end of stream.
      directed = {directed, row(CMD_READ,  8'h00, 7'd5,   1'b1, 1'b0, 11'd0)};
      directed = {directed, row(CMD_PEEK,  8'h00, 7'd0,   1'b1, 1'b0, 11'd0)};
      directed = {directed, row(CMD_POP,   8'h00, 7'd64,  1'b1, 1'b0, 11'd0)};
      directed = {directed, row(CMD_RSVD5, 8'hFF, 7'd127, 1'b1, 1'b0, 11'd0)};
      directed = {directed, row(CMD_RSVD6, 8'h00, 7'd1,   1'b1, 1'b0, 11'd0)};
      directed = {directed, row(CMD_RSVD7, 8'h81, 7'd64,  1'b1, 1'b0, 11'd0)};
      directed = {directed, row(CMD_WRITE, 8'h00, 7'd0,   1'b1, 1'b1, 11'd1)};
      directed = {directed, row(CMD_WRITE, 8'hFF, 7'd127, 1'b1, 1'b1, 11'd2)};
      directed = {directed, row(CMD_WRITE, 8'hA5, 7'd0,   1'b1, 1'b1, 11'd3)};
      directed = {directed, row(CMD_WRITE, 8'h5A, 7'd0,   1'b1, 1'b1, 11'd4)};
      directed = {directed, row(CMD_PEEK,  8'h00, 7'd127)};
      directed = {directed, row(CMD_READ,  8'h00, 7'd0,   1'b1, 1'b0, 11'd4)};
      directed = {directed, row(CMD_READ,  8'h00, 7'd2)};
      directed = {directed, row(CMD_POP,   8'h00, 7'd1,   1'b1, 1'b0, 11'd1)};
      directed = {directed, row(CMD_END,   8'h00, 7'd0,   1'b1, 1'b0, 11'd1)};
      directed = {directed, row(CMD_WRITE, 8'h3C, 7'd0,   1'b1, 1'b1, 11'd2)};
      directed = {directed, row(CMD_READ,  8'h00, 7'd127)};
      directed = {directed, row(CMD_READ,  8'h00, 7'd1,   1'b1, 1'b0, 11'd0)};
      directed = {directed, row(CMD_END,   8'h00, 7'd0,   1'b1, 1'b0, 11'd0)};
      foreach (directed[i]) send_beat(directed[i]);

      // Capacity above the store depth; finish with a burst of writes so that the
      // next, much smaller capacity lands below the occupancy.
      run_phase(11'd2047, 0, 0, 60, 80);
      repeat (20) send_beat(row(CMD_WRITE, 8'($urandom), 7'($urandom)));
      run_phase(11'd3, 55, 0, 40, 50);
      run_phase(11'd0, 0, 55, 50, 30);
      run_phase(11'd1, 22, 22, 50, 40);

      // Receiver holds off while the sender keeps pushing until the input stalls.
      set_capacity(11'd64);
      send_idle_pct   = 0;
      recv_stall_pct <= 0;
      hold_request   <= 1'b1;
      repeat (60) send_beat(random_beat(70));

      run_phase(11'd1024, 22, 22, 55, 40);
      drain_results();
      repeat (40) send_beat(random_beat(55));
      run_phase(11'd1000, 0, 55, 55, 40);

      drain_results();
      repeat (SETTLE_CYCLES * 4) @(posedge clock);
      if (fault_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bbf_pkg.sv
rtl/bbf_ram.sv
rtl/bbf_front.sv
rtl/bbf_job_queue.sv
rtl/bbf_back.sv
rtl/bounded_byte_fifo.sv
rtl/bbf_checker.sv
verif/bounded_byte_fifo_tb.sv
